// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold on every clock edge outside reset
`define SRV_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SRV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SRV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SRV_ASSERT(label, clk, rst_n, cond, msg)
`define SRV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SRV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/srv_pkg.sv =====
// types, constants and codes of the sonar range validator
`timescale 1ns / 1ps

package srv_pkg;

    // field widths
    localparam int DIST_W     = 10;
    localparam int ECHO_W     = 16;
    localparam int MODE_W     = 2;
    localparam int STAT_W     = 2;
    localparam int VAR_W      = 6;
    localparam int ATT_W      = 4;
    localparam int HOLD_W     = 16;
    localparam int TOUT_W     = 16;
    localparam int HCNT_W     = HOLD_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = ((ECHO_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DIST_W + 7) / 8) * 8;

    // echo time to centimetres: t * 17983 / 2^20, about t * 0.01715
    localparam int SCALE_MUL   = 17983;
    localparam int MUL_W       = 15;
    localparam int SCALE_SHIFT = 20;
    localparam int PROD_W      = ECHO_W + MUL_W;
    localparam int DIST_MAX    = (1 << DIST_W) - 1;

    // register reset values
    localparam logic [VAR_W-1:0]  VAR_RST  = VAR_W'(5);
    localparam logic [ATT_W-1:0]  ATT_RST  = ATT_W'(5);
    localparam logic [HOLD_W-1:0] HOLD_RST = HOLD_W'(250);
    localparam logic [TOUT_W-1:0] TOUT_RST = TOUT_W'(30000);
    localparam logic [DIST_W-1:0] LAST_RST = DIST_W'(1);

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_REQ  = 2'd1,
        MODE_ECHO = 2'd2
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_HELD    = 2'd0,
        ST_FRESH   = 2'd1,
        ST_FAILED  = 2'd2,
        ST_TRIGGER = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VARIANCE = 2'd0,
        CFG_ATTEMPT  = 2'd1,
        CFG_HOLDOFF  = 2'd2,
        CFG_TIMEOUT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [VAR_W-1:0]  variance_limit;
        logic [ATT_W-1:0]  attempt_limit;
        logic [HOLD_W-1:0] holdoff_ms;
        logic [TOUT_W-1:0] echo_timeout_us;
    } t_cfg;

    // converted beat handed from the input stage to the pair logic
    typedef struct packed {
        logic              valid;
        t_mode             mode;
        logic [DIST_W-1:0] dist_cm;
    } t_stg;

endpackage

// ===== rtl/sonar_range_validator.sv =====
// top level of the sonar range validator: config registers and stream ports
// path: an input beat is registered in the stage register, then in the result register, which offers it
// throughput: one input beat per cycle while the result side keeps tready high
// the single result register sets the rate: a held result stalls input beyond one item
// reset: synchronous active-low i_rst_n clears run state, hold-off and both stages,
// and loads the registers with their defaults
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sonar_range_validator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [srv_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [srv_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [srv_pkg::S_TDATA_W-1:0] i_s_tdata,   // [15:0] echo_us
    input  logic [srv_pkg::MODE_W-1:0]    i_s_tuser,   // [1:0] mode
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [srv_pkg::M_TDATA_W-1:0] o_m_tdata,   // [9:0] distance_cm, rest zero
    output logic [srv_pkg::STAT_W-1:0]    o_m_tuser    // [1:0] status
);

    srv_pkg::t_cfg              r_cfg;
    srv_pkg::t_stg              w_stg;
    logic                       w_load;
    logic                       w_adv;
    logic [srv_pkg::DIST_W-1:0] w_dist;
    srv_pkg::t_status           w_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.variance_limit  <= srv_pkg::VAR_RST;
            r_cfg.attempt_limit   <= srv_pkg::ATT_RST;
            r_cfg.holdoff_ms      <= srv_pkg::HOLD_RST;
            r_cfg.echo_timeout_us <= srv_pkg::TOUT_RST;
        end else if (i_cfg_we) begin
            case (srv_pkg::t_cfg_idx'(i_cfg_addr))
                srv_pkg::CFG_VARIANCE: r_cfg.variance_limit  <= i_cfg_wdata[srv_pkg::VAR_W-1:0];
                srv_pkg::CFG_ATTEMPT:  r_cfg.attempt_limit   <= i_cfg_wdata[srv_pkg::ATT_W-1:0];
                srv_pkg::CFG_HOLDOFF:  r_cfg.holdoff_ms      <= i_cfg_wdata[srv_pkg::HOLD_W-1:0];
                srv_pkg::CFG_TIMEOUT:  r_cfg.echo_timeout_us <= i_cfg_wdata[srv_pkg::TOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input beat taken when the stage is empty or moving on
    assign o_s_tready = !w_stg.valid || w_adv;
    assign w_load     = i_s_tvalid && o_s_tready;

    srv_echo_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_load  (w_load),
        .i_mode  (i_s_tuser),
        .i_echo  (i_s_tdata[srv_pkg::ECHO_W-1:0]),
        .i_adv   (w_adv),
        .o_stg   (w_stg)
    );

    srv_pair_ctrl u_pair (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_stg      (w_stg),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_dist   (w_dist),
        .o_m_status (w_status),
        .o_adv      (w_adv)
    );

    assign o_m_tdata = srv_pkg::M_TDATA_W'(w_dist);
    assign o_m_tuser = w_status;

    // a fresh distance is the average of two positive readings, never zero
    `SRV_ASSERT_IMPL(a_fresh_nonzero, i_clk, i_rst_n,
        o_m_tvalid && (w_status == srv_pkg::ST_FRESH),
        w_dist != '0, "fresh distance is zero")

    // trigger and failure beats carry no distance
    `SRV_ASSERT_IMPL(a_zero_dist, i_clk, i_rst_n,
        o_m_tvalid && ((w_status == srv_pkg::ST_TRIGGER) || (w_status == srv_pkg::ST_FAILED)),
        w_dist == '0, "trigger or failure beat with distance")

    // a staged item blocked by a full result register is kept
    `SRV_ASSERT_NEXT(a_stage_kept, i_clk, i_rst_n,
        w_stg.valid && !w_adv, w_stg.valid, "staged item lost under stall")

endmodule

// ===== rtl/srv_echo_conv.sv =====
// input stage: echo width to distance conversion and stage register
`timescale 1ns / 1ps

module srv_echo_conv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  srv_pkg::t_cfg              i_cfg,
    input  logic                       i_load,
    input  logic [srv_pkg::MODE_W-1:0] i_mode,
    input  logic [srv_pkg::ECHO_W-1:0] i_echo,
    input  logic                       i_adv,
    output srv_pkg::t_stg              o_stg
);

    logic [srv_pkg::PROD_W-1:0] w_prod;
    logic [srv_pkg::PROD_W-1:0] w_quot;
    logic                       w_echo_ok;
    logic [srv_pkg::DIST_W-1:0] n_dist;

    logic                       r_valid;
    srv_pkg::t_mode             r_mode;
    logic [srv_pkg::DIST_W-1:0] r_dist;

    // fixed point scale, saturate at the distance range, zero on no echo or timeout
    always_comb begin
        w_prod    = srv_pkg::PROD_W'(i_echo) * srv_pkg::PROD_W'(srv_pkg::SCALE_MUL);
        w_quot    = w_prod >> srv_pkg::SCALE_SHIFT;
        w_echo_ok = (i_echo != '0) && (i_echo <= i_cfg.echo_timeout_us);
        if (!w_echo_ok) begin
            n_dist = '0;
        end else if (w_quot > srv_pkg::PROD_W'(srv_pkg::DIST_MAX)) begin
            n_dist = srv_pkg::DIST_W'(srv_pkg::DIST_MAX);
        end else begin
            n_dist = w_quot[srv_pkg::DIST_W-1:0];
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mode <= srv_pkg::t_mode'(i_mode);
            r_dist <= n_dist;
        end
    end

    assign o_stg = '{valid: r_valid, mode: r_mode, dist_cm: r_dist};

endmodule

// ===== rtl/srv_pair_ctrl.sv =====
// run control, pair qualification, hold-off and result register
`timescale 1ns / 1ps

module srv_pair_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  srv_pkg::t_cfg              i_cfg,
    input  srv_pkg::t_stg              i_stg,
    input  logic                       i_m_tready,
    output logic                       o_m_tvalid,
    output logic [srv_pkg::DIST_W-1:0] o_m_dist,
    output srv_pkg::t_status           o_m_status,
    output logic                       o_adv
);

    logic [srv_pkg::HCNT_W-1:0] r_holdoff;
    logic [srv_pkg::DIST_W-1:0] r_last_good;
    logic [srv_pkg::DIST_W-1:0] r_first;
    logic                       r_have_first;
    logic [srv_pkg::ATT_W-1:0]  r_failed;
    logic                       r_run_active;
    logic                       r_out_valid;
    logic [srv_pkg::DIST_W-1:0] r_out_dist;
    srv_pkg::t_status           r_out_status;

    logic [srv_pkg::HCNT_W-1:0] n_holdoff;
    logic [srv_pkg::DIST_W-1:0] n_last_good;
    logic [srv_pkg::DIST_W-1:0] n_first;
    logic                       n_have_first;
    logic [srv_pkg::ATT_W-1:0]  n_failed;
    logic                       n_run_active;

    logic                       w_out_free;
    logic                       w_fire;
    logic                       w_res_valid;
    logic [srv_pkg::DIST_W-1:0] w_res_dist;
    srv_pkg::t_status           w_res_status;
    logic [srv_pkg::DIST_W-1:0] w_diff;
    logic [srv_pkg::DIST_W:0]   w_sum;
    logic                       w_pair_ok;
    logic [srv_pkg::ATT_W-1:0]  w_failed_inc;

    // the stage moves on when the result register is free or being drained
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_fire     = i_stg.valid && w_out_free;
    assign o_adv      = w_fire;

    // pair arithmetic
    always_comb begin
        w_diff       = (r_first > i_stg.dist_cm) ? (r_first - i_stg.dist_cm)
                                                 : (i_stg.dist_cm - r_first);
        w_sum        = {1'b0, r_first} + {1'b0, i_stg.dist_cm};
        w_pair_ok    = (r_first != '0) && (i_stg.dist_cm != '0)
                       && (w_diff <= srv_pkg::DIST_W'(i_cfg.variance_limit));
        w_failed_inc = r_failed + srv_pkg::ATT_W'(1);
    end

    // run control and result selection
    always_comb begin
        n_holdoff    = r_holdoff;
        n_last_good  = r_last_good;
        n_first      = r_first;
        n_have_first = r_have_first;
        n_failed     = r_failed;
        n_run_active = r_run_active;
        w_res_valid  = 1'b0;
        w_res_dist   = '0;
        w_res_status = srv_pkg::ST_TRIGGER;
        if (w_fire) begin
            case (i_stg.mode)
                srv_pkg::MODE_TICK: begin
                    if (r_holdoff != '0) begin
                        n_holdoff = r_holdoff - srv_pkg::HCNT_W'(1);
                    end
                end
                srv_pkg::MODE_REQ: begin
                    if (!r_run_active) begin
                        w_res_valid = 1'b1;
                        if (r_holdoff != '0) begin
                            w_res_dist   = r_last_good;
                            w_res_status = srv_pkg::ST_HELD;
                        end else begin
                            n_run_active = 1'b1;
                            n_have_first = 1'b0;
                            n_failed     = '0;
                        end
                    end
                end
                srv_pkg::MODE_ECHO: begin
                    if (r_run_active) begin
                        w_res_valid = 1'b1;
                        if (!r_have_first) begin
                            n_first      = i_stg.dist_cm;
                            n_have_first = 1'b1;
                        end else begin
                            n_have_first = 1'b0;
                            if (w_pair_ok) begin
                                w_res_dist   = w_sum[srv_pkg::DIST_W:1];
                                w_res_status = srv_pkg::ST_FRESH;
                                n_last_good  = w_sum[srv_pkg::DIST_W:1];
                                n_run_active = 1'b0;
                                n_failed     = '0;
                                n_holdoff    = {1'b0, i_cfg.holdoff_ms} + srv_pkg::HCNT_W'(1);
                            end else if (w_failed_inc >= i_cfg.attempt_limit) begin
                                w_res_status = srv_pkg::ST_FAILED;
                                n_run_active = 1'b0;
                                n_failed     = '0;
                                n_holdoff    = {1'b0, i_cfg.holdoff_ms} + srv_pkg::HCNT_W'(1);
                            end else begin
                                n_failed = w_failed_inc;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff    <= '0;
            r_last_good  <= srv_pkg::LAST_RST;
            r_first      <= '0;
            r_have_first <= 1'b0;
            r_failed     <= '0;
            r_run_active <= 1'b0;
        end else begin
            r_holdoff    <= n_holdoff;
            r_last_good  <= n_last_good;
            r_first      <= n_first;
            r_have_first <= n_have_first;
            r_failed     <= n_failed;
            r_run_active <= n_run_active;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out_dist   <= w_res_dist;
            r_out_status <= w_res_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_dist   = r_out_dist;
    assign o_m_status = r_out_status;

endmodule
